### src/mcc_pkg.sv
package mcc_pkg;

    localparam int MAX_CODE_LEN_DEF = 5;
    localparam int MAX_CODE_LEN_MIN = 5;
    localparam int NUM_RESULTS      = 6;
    localparam int ROM_SYM_BITS     = 5;
    localparam int NUM_CHAR_CODES   = 36;

    localparam logic [5:0] SPACE_IDX = 6'd36;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic       DIR_ENCODE = 1'b0;
    localparam logic       DIR_DECODE = 1'b1;
    localparam logic [7:0] SEP_RESET  = 8'h20;

    localparam int          APB_AW      = 3;
    localparam logic        REG_DIRECTION = 1'b0;
    localparam logic        REG_SEPARATOR = 1'b1;

    typedef struct packed {
        logic [2:0] len;
        logic [4:0] bits;   // MSB first within len, dash = 1
    } t_code;

    typedef struct packed {
        logic       found;
        logic [5:0] idx;
    } t_lookup;

    typedef struct packed {
        logic [2:0]      count;
        logic [5:0][7:0] bytes;  // bytes[0] goes out first
    } t_run;

    function automatic t_code mcc_rom(input logic [5:0] idx);
        t_code c;
        unique case (idx)
            6'd0:  c = {3'd2, 5'b00001};
            6'd1:  c = {3'd4, 5'b01000};
            6'd2:  c = {3'd4, 5'b01010};
            6'd3:  c = {3'd3, 5'b00100};
            6'd4:  c = {3'd1, 5'b00000};
            6'd5:  c = {3'd4, 5'b00010};
            6'd6:  c = {3'd3, 5'b00110};
            6'd7:  c = {3'd4, 5'b00000};
            6'd8:  c = {3'd2, 5'b00000};
            6'd9:  c = {3'd4, 5'b00111};
            6'd10: c = {3'd3, 5'b00101};
            6'd11: c = {3'd4, 5'b00100};
            6'd12: c = {3'd2, 5'b00011};
            6'd13: c = {3'd2, 5'b00010};
            6'd14: c = {3'd3, 5'b00111};
            6'd15: c = {3'd4, 5'b00110};
            6'd16: c = {3'd4, 5'b01101};
            6'd17: c = {3'd3, 5'b00010};
            6'd18: c = {3'd3, 5'b00000};
            6'd19: c = {3'd1, 5'b00001};
            6'd20: c = {3'd3, 5'b00001};
            6'd21: c = {3'd4, 5'b00001};
            6'd22: c = {3'd3, 5'b00011};
            6'd23: c = {3'd4, 5'b01001};
            6'd24: c = {3'd4, 5'b01011};
            6'd25: c = {3'd4, 5'b01100};
            6'd26: c = {3'd5, 5'b11111};
            6'd27: c = {3'd5, 5'b01111};
            6'd28: c = {3'd5, 5'b00111};
            6'd29: c = {3'd5, 5'b00011};
            6'd30: c = {3'd5, 5'b00001};
            6'd31: c = {3'd5, 5'b00000};
            6'd32: c = {3'd5, 5'b10000};
            6'd33: c = {3'd5, 5'b11000};
            6'd34: c = {3'd5, 5'b11100};
            6'd35: c = {3'd5, 5'b11110};
            6'd36: c = {3'd1, 5'b00000};   // word gap, sent as slash
            default: c = {3'd0, 5'b00000};
        endcase
        return c;
    endfunction

    // ASCII character that a ROM entry below the word gap stands for
    function automatic logic [7:0] mcc_char_of(input logic [5:0] idx);
        logic [7:0] ch;
        if (idx < 6'd26) begin
            ch = 8'h41 + {2'b00, idx};
        end else begin
            ch = 8'h30 + {2'b00, idx} - 8'd26;
        end
        return ch;
    endfunction

    // Case-folded ROM lookup of an input byte
    function automatic t_lookup mcc_lookup(input logic [7:0] c_in);
        t_lookup    r;
        logic [7:0] c;
        c = c_in;
        if (c >= 8'h61 && c <= 8'h7A) begin
            c = c - 8'h20;
        end
        r.found = 1'b1;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.idx = 6'(c - 8'h41);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.idx = 6'(c - 8'h30 + 8'd26);
        end else if (c == CH_SPACE) begin
            r.idx = SPACE_IDX;
        end else begin
            r.found = 1'b0;
            r.idx   = 6'd0;
        end
        return r;
    endfunction

endpackage

### src/mcc_engine.sv
module mcc_engine #(
    parameter int MAX_CODE_LEN = mcc_pkg::MAX_CODE_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_proc,
    input  logic [7:0]    i_char,
    input  logic          i_start,
    input  logic          i_end,
    input  logic          i_direction,
    input  logic [7:0]    i_separator,
    output mcc_pkg::t_run o_run
);
    import mcc_pkg::*;

    localparam int LW = $clog2(MAX_CODE_LEN + 1);

    logic [MAX_CODE_LEN-1:0] r_sym, n_sym;
    logic [LW-1:0]           r_len, n_len;
    logic                    r_inv, n_inv;
    logic                    r_emitted, n_emitted;

    // state as seen after a message start clears it
    logic [MAX_CODE_LEN-1:0] p_sym, u_sym, f_sym;
    logic [LW-1:0]           p_len, u_len, f_len;
    logic                    p_inv, u_inv, f_inv, p_emit;

    t_lookup    lk;
    t_code      code;
    logic [4:0] aligned;
    logic [4:0][7:0] syms;
    t_run       enc_run, dec_run;

    logic       is_sp, is_sl, is_sym, can_add, do_flush, hit, dec_ok;
    logic [7:0] dec_ch;
    t_code      rc;

    always_comb begin
        p_sym  = i_start ? '0 : r_sym;
        p_len  = i_start ? '0 : r_len;
        p_inv  = i_start ? 1'b0 : r_inv;
        p_emit = i_start ? 1'b0 : r_emitted;
    end

    // encode: code symbols left-aligned, separator in front after the first code
    always_comb begin
        lk      = mcc_lookup(i_char);
        code    = mcc_rom(lk.idx);
        aligned = 5'(code.bits << (3'd5 - code.len));
        for (int k = 0; k < 5; k++) begin
            if (lk.idx == SPACE_IDX) begin
                syms[k] = CH_SLASH;
            end else begin
                syms[k] = aligned[4-k] ? CH_DASH : CH_DOT;
            end
        end
        enc_run.count = lk.found ? (code.len + {2'b00, p_emit}) : 3'd0;
        enc_run.bytes[5] = p_emit ? syms[4] : 8'h00;
        for (int k = 1; k < 5; k++) begin
            enc_run.bytes[k] = p_emit ? syms[k-1] : syms[k];
        end
        enc_run.bytes[0] = p_emit ? i_separator : syms[0];
    end

    // decode: shift in symbol, then flush on gap or message end
    always_comb begin
        is_sp   = (i_char == CH_SPACE);
        is_sl   = (i_char == CH_SLASH);
        is_sym  = (i_char == CH_DOT) || (i_char == CH_DASH);
        can_add = is_sym && (p_len < LW'(MAX_CODE_LEN));
        u_sym   = can_add ? {p_sym[MAX_CODE_LEN-2:0], (i_char == CH_DASH)} : p_sym;
        u_len   = can_add ? p_len + LW'(1) : p_len;
        u_inv   = p_inv | (!is_sp && !is_sl && !can_add);

        do_flush = is_sp || is_sl || i_end;
        f_sym    = (is_sp || is_sl) ? p_sym : u_sym;
        f_len    = (is_sp || is_sl) ? p_len : u_len;
        f_inv    = (is_sp || is_sl) ? p_inv : u_inv;

        hit    = 1'b0;
        dec_ch = 8'h00;
        for (int i = 0; i < NUM_CHAR_CODES; i++) begin
            rc = mcc_rom(6'(i));
            if (f_len == LW'(rc.len) && f_sym == MAX_CODE_LEN'(rc.bits)) begin
                hit    = 1'b1;
                dec_ch = dec_ch | mcc_char_of(6'(i));
            end
        end
        dec_ok = do_flush && !f_inv && (f_len != '0) && hit;

        dec_run.count    = {2'b00, dec_ok} + {2'b00, is_sl};
        dec_run.bytes    = '0;
        dec_run.bytes[0] = dec_ok ? dec_ch : CH_SPACE;
        dec_run.bytes[1] = CH_SPACE;
    end

    assign o_run = (i_direction == DIR_ENCODE) ? enc_run : dec_run;

    always_comb begin
        if (i_direction == DIR_ENCODE) begin
            n_emitted = p_emit | lk.found;
            n_sym     = p_sym;
            n_len     = p_len;
            n_inv     = p_inv;
        end else begin
            n_emitted = p_emit;
            n_sym     = do_flush ? '0 : u_sym;
            n_len     = do_flush ? '0 : u_len;
            n_inv     = do_flush ? 1'b0 : u_inv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym     <= '0;
            r_len     <= '0;
            r_inv     <= 1'b0;
            r_emitted <= 1'b0;
        end else if (i_proc) begin
            r_sym     <= n_sym;
            r_len     <= n_len;
            r_inv     <= n_inv;
            r_emitted <= n_emitted;
        end
    end

endmodule

### src/mcc_ser.sv
module mcc_ser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load_req,
    input  mcc_pkg::t_run i_run,
    input  logic          i_stall,
    output logic          o_free,
    output logic          o_valid,
    output logic [7:0]    o_char,
    output logic          o_last
);
    import mcc_pkg::*;

    logic [2:0]      r_cnt;
    logic [5:0][7:0] r_bytes;
    logic            take, load;

    assign o_valid = (r_cnt != 3'd0);
    assign take    = o_valid && !i_stall;
    assign o_free  = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && take);
    assign load    = i_load_req && o_free;
    assign o_char  = r_bytes[0];
    assign o_last  = (r_cnt == 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (load) begin
            r_cnt <= i_run.count;
        end else if (take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= i_run.bytes;
        end else if (take) begin
            for (int k = 0; k < NUM_RESULTS - 1; k++) begin
                r_bytes[k] <= r_bytes[k+1];
            end
        end
    end

endmodule

### src/morse_code_codec_core.sv
// Throughput: one result byte per cycle while the receiver does not stall; an item
// holds the output shifter until all its results (0 to 6: separator plus up to five
// symbols) have been taken.
// An item with no results passes through the input register without occupying the shifter.
// Reset (i_rst_n, synchronous, active low): encode direction, separator 0x20.
module morse_code_codec_core #(
    parameter int MAX_CODE_LEN = mcc_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_char_in,
    input  logic                       i_msg_start,
    input  logic                       i_msg_end,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [7:0]                 o_char_out,
    output logic                       o_last_of_run,
    // register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mcc_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import mcc_pkg::*;

    // config registers
    logic       r_direction;
    logic [7:0] r_separator;
    logic       reg_wr;

    // input register
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_start, r_end;

    logic       in_take, ser_free, proc;
    t_run       run;

    // APB: zero wait state, address bit 2 selects the register
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DIR_ENCODE;
            r_separator <= SEP_RESET;
        end else if (reg_wr) begin
            if (paddr[2] == REG_DIRECTION) begin
                r_direction <= pwdata[0];
            end else begin
                r_separator <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_SEPARATOR) begin
            prdata = {24'h0, r_separator};
        end else begin
            prdata = {31'h0, r_direction};
        end
    end

    // Input register holds one item; it moves on into the output shifter as soon
    // as the shifter is empty or handing out its last byte this cycle, so a
    // stream of items keeps the result side busy without bubbles.
    assign proc    = r_in_valid && ser_free;
    assign o_stall = r_in_valid && !ser_free;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_char  <= i_char_in;
            r_start <= i_msg_start;
            r_end   <= i_msg_end;
        end
    end

    // codec: lookup, pending-code state, result list for one item
    mcc_engine #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_proc      (proc),
        .i_char      (r_char),
        .i_start     (r_start),
        .i_end       (r_end),
        .i_direction (r_direction),
        .i_separator (r_separator),
        .o_run       (run)
    );

    // result register: holds the run and sends one byte per transfer
    mcc_ser u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load_req (r_in_valid),
        .i_run      (run),
        .i_stall    (i_stall),
        .o_free     (ser_free),
        .o_valid    (o_valid),
        .o_char     (o_char_out),
        .o_last     (o_last_of_run)
    );

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

// Morse codec testbench: a queue-fed driver offers message bytes, a scoreboard-style
// monitor compares every output byte against a behavioral codec kept in lockstep.
module tb_top;
    import mcc_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int SETTLE_CYCLES    = 8;     // margin for trailing items that produce no output
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int RANDOM_PHASES    = 6;
    localparam int RANDOM_ITEMS     = 192;
    localparam int MAX_SYMS         = MAX_CODE_LEN_DEF;
    localparam int N_LETTERS        = 26;
    localparam int MAX_PRINTED      = 30;

    localparam logic [APB_AW-1:0] ADDR_DIRECTION = {REG_DIRECTION, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SEPARATOR = {REG_SEPARATOR, 2'b00};

    localparam logic [7:0] ASCII_A  = "A";
    localparam logic [7:0] ASCII_Z  = "Z";
    localparam logic [7:0] ASCII_LA = "a";
    localparam logic [7:0] ASCII_LZ = "z";
    localparam logic [7:0] ASCII_0  = "0";
    localparam logic [7:0] ASCII_9  = "9";
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef struct {
        logic [7:0] ch;
        logic       first;
        logic       last;
    } t_in_byte;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_out_byte;

    // letters, digits, then the word gap
    string morse_table [0:36] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
        "---..", "----.",
        "/"
    };
    // well-formed four-symbol codes that map to nothing
    string unknown_codes [0:3] = '{"..--", ".-.-", "---.", "----"};

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic                o_stall;
    logic [7:0]          i_char_in     = 8'h00;
    logic                i_msg_start   = 1'b0;
    logic                i_msg_end     = 1'b0;
    logic                o_valid;
    logic                i_stall       = 1'b0;
    logic [7:0]          o_char_out;
    logic                o_last_of_run;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [APB_AW-1:0]   paddr         = '0;
    logic [31:0]         pwdata        = '0;
    logic [31:0]         prdata;
    logic                pready;

    morse_code_codec_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_in     (i_char_in),
        .i_msg_start   (i_msg_start),
        .i_msg_end     (i_msg_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_char_out    (o_char_out),
        .o_last_of_run (o_last_of_run),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b1;
        #HALF_PERIOD;
        i_clk = 1'b0;
        #HALF_PERIOD;
    end

    // ------------------------------------------------------------------
    // Behavioral codec state and registers
    // ------------------------------------------------------------------
    logic       dir_model  = DIR_ENCODE;
    logic [7:0] sep_model  = SEP_RESET;
    logic [4:0] code_bits  = '0;    // pending dots/dashes, oldest symbol in the top bit of code_len
    logic [2:0] code_len   = '0;
    logic       code_bad   = 1'b0;  // junk or overlong seen, code will be dropped
    logic       code_sent  = 1'b0;  // a code already went out in this message

    t_in_byte  outbound_bytes [$];  // message bytes waiting for the driver
    t_out_byte expected_bytes [$];  // predicted output bytes, oldest first
    t_out_byte run_bytes      [$];  // scratch: output of one input byte
    logic [7:0] msg_bytes     [$];  // scratch: one random message under construction

    int  items_queued    = 0;
    int  items_sent      = 0;
    int  encode_items    = 0;
    int  decode_items    = 0;
    int  results_checked = 0;
    int  reg_writes      = 0;
    int  mismatches      = 0;

    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    bit  hold_req   = 1'b0;
    bit  hold_taken = 1'b0;
    int  hold_left  = 0;
    int  stall_left = 0;
    int  send_gap   = 0;
    t_in_byte  cur_in;
    t_out_byte want_out;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED) begin
            $display("%0t mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    // mostly back to back, sometimes a short gap, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 96) begin
            return $urandom_range(4, 9);
        end
        return $urandom_range(15, 40);
    endfunction

    function automatic void clear_code();
        code_bits = '0;
        code_len  = '0;
        code_bad  = 1'b0;
    endfunction

    // at most six output bytes per input byte
    function automatic void push_run(input logic [7:0] ch);
        t_out_byte ob;
        if (run_bytes.size() < NUM_RESULTS) begin
            ob.ch   = ch;
            ob.last = 1'b0;
            run_bytes.push_back(ob);
        end
    endfunction

    // emit the character of the pending code if it is a real one, then forget it
    function automatic void flush_code();
        int         i;
        int         k;
        string      sym;
        logic [4:0] bits;
        logic [7:0] ch;
        bit         hit;
        hit = 1'b0;
        if (!code_bad && code_len != 0) begin
            for (i = 0; i < NUM_CHAR_CODES && !hit; i++) begin
                sym  = morse_table[i];
                bits = '0;
                for (k = 0; k < sym.len(); k++) begin
                    bits = {bits[3:0], sym[k] == CH_DASH};
                end
                if (sym.len() == code_len && bits == code_bits) begin
                    hit = 1'b1;
                    ch  = (i < N_LETTERS) ? 8'(ASCII_A + i) : 8'(ASCII_0 + i - N_LETTERS);
                    push_run(ch);
                end
            end
        end
        clear_code();
    endfunction

    // work out the output bytes caused by one accepted input byte
    function automatic void predict_codec_bytes(input t_in_byte it);
        int         idx;
        int         k;
        string      sym;
        logic [7:0] u;
        t_out_byte  ob;
        run_bytes.delete();
        if (it.first) begin
            code_sent = 1'b0;
            clear_code();
        end
        if (dir_model == DIR_ENCODE) begin
            encode_items++;
            u = it.ch;
            if (u >= ASCII_LA && u <= ASCII_LZ) begin
                u = u - CASE_BIT;
            end
            idx = -1;
            if (u >= ASCII_A && u <= ASCII_Z) begin
                idx = u - ASCII_A;
            end else if (u >= ASCII_0 && u <= ASCII_9) begin
                idx = N_LETTERS + (u - ASCII_0);
            end else if (u == CH_SPACE) begin
                idx = SPACE_IDX;
            end
            if (idx >= 0) begin
                if (code_sent) begin
                    push_run(sep_model);
                end
                sym = morse_table[idx];
                for (k = 0; k < sym.len(); k++) begin
                    push_run(sym[k]);
                end
                code_sent = 1'b1;
            end
        end else begin
            decode_items++;
            if (it.ch == CH_SPACE || it.ch == CH_SLASH) begin
                flush_code();
                if (it.ch == CH_SLASH) begin
                    push_run(CH_SPACE);
                end
            end else if ((it.ch == CH_DOT || it.ch == CH_DASH) && code_len < MAX_SYMS) begin
                code_bits = {code_bits[3:0], it.ch == CH_DASH};
                code_len  = code_len + 3'd1;
            end else begin
                code_bad = 1'b1;
            end
            if (it.last) begin
                flush_code();
            end
        end
        if (run_bytes.size() != 0) begin
            ob      = run_bytes.pop_back();
            ob.last = 1'b1;
            run_bytes.push_back(ob);
        end
        for (k = 0; k < run_bytes.size(); k++) begin
            expected_bytes.push_back(run_bytes[k]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued bytes, predicts on each input transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_codec_bytes(cur_in);
                items_sent++;
            end
            // payload only moves when nothing is pending or the last one went through
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (outbound_bytes.size() != 0) begin
                    cur_in = outbound_bytes.pop_front();
                    i_char_in   <= cur_in.ch;
                    i_msg_start <= cur_in.first;
                    i_msg_end   <= cur_in.last;
                    i_valid     <= 1'b1;
                    send_gap = tx_idle_en ? pick_gap() : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each output transfer, drives the receiver stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected output byte 0x%02h", o_char_out));
                end else begin
                    want_out = expected_bytes.pop_front();
                    results_checked++;
                    if (o_char_out !== want_out.ch) begin
                        report_mismatch($sformatf("char_out 0x%02h, predicted 0x%02h",
                                                  o_char_out, want_out.ch));
                    end
                    if (o_last_of_run !== want_out.last) begin
                        report_mismatch($sformatf("last_of_run %b, predicted %b on 0x%02h",
                                                  o_last_of_run, want_out.last, want_out.ch));
                    end
                end
            end
            // one long hold-off on request, so the input side backs up
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer ends the run
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || psel || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: %0d cycles without a transfer, %0d bytes sent of %0d, %0d outputs owed",
                 WATCHDOG_LIMIT, items_sent, items_queued, expected_bytes.size());
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input logic [7:0] ch, input logic first, input logic last);
        t_in_byte it;
        it.ch    = ch;
        it.first = first;
        it.last  = last;
        outbound_bytes.push_back(it);
        items_queued++;
    endtask

    // one whole message: start on the first byte, end on the last
    task automatic queue_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            queue_item(s[k], k == 0, k == s.len() - 1);
        end
    endtask

    function automatic void add_symbols(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            msg_bytes.push_back(s[k]);
        end
    endfunction

    // register write followed by a read-back of the same register
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // write lands at this edge; psel stays up for the read setup
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_writes++;
        if (addr == ADDR_DIRECTION) begin
            dir_model = value[0];
            if (prdata[0] !== dir_model) begin
                report_mismatch($sformatf("direction reads %b, wrote %b", prdata[0], dir_model));
            end
        end else begin
            sep_model = value[7:0];
            if (prdata[7:0] !== sep_model) begin
                report_mismatch($sformatf("separator reads 0x%02h, wrote 0x%02h",
                                          prdata[7:0], sep_model));
            end
        end
    endtask

    // everything sent and answered, then a margin of SETTLE_CYCLES for byte(s) with no output
    task automatic settle_block();
        while (items_sent != items_queued || expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random messages in the current direction; the last one may be cut short,
    // so pending state can straddle a register change
    task automatic queue_random_messages(input int budget);
        logic [7:0] jb;
        int         r;
        int         n;
        int         k;
        int         j;
        bit         closed;
        while (budget > 0) begin
            msg_bytes.delete();
            r = $urandom_range(0, 9);
            if (r == 0) begin
                // noise: any byte with any framing
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++) begin
                    queue_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                end
                budget -= n;
                continue;
            end
            if (dir_model == DIR_ENCODE) begin
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++) begin
                    r = $urandom_range(0, 9);
                    if (r < 5) begin
                        jb = 8'(ASCII_A + $urandom_range(0, N_LETTERS - 1));
                        if ($urandom_range(0, 1)) begin
                            jb = jb + CASE_BIT;
                        end
                    end else if (r < 7) begin
                        jb = 8'(ASCII_0 + $urandom_range(0, 9));
                    end else if (r < 8) begin
                        jb = CH_SPACE;
                    end else begin
                        jb = 8'($urandom_range(0, 255));
                    end
                    msg_bytes.push_back(jb);
                end
            end else begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++) begin
                    r = $urandom_range(0, 19);
                    if (r < 15) begin
                        add_symbols(morse_table[$urandom_range(0, NUM_CHAR_CODES - 1)]);
                    end else if (r < 17) begin
                        add_symbols(unknown_codes[$urandom_range(0, 3)]);
                    end else if (r < 18) begin
                        // overlong
                        for (j = $urandom_range(6, 7); j > 0; j--) begin
                            msg_bytes.push_back($urandom_range(0, 1) ? CH_DASH : CH_DOT);
                        end
                    end else begin
                        // junk byte inside an otherwise valid code
                        add_symbols(morse_table[$urandom_range(0, NUM_CHAR_CODES - 1)]);
                        do begin
                            jb = 8'($urandom_range(0, 255));
                        end while (jb == CH_DOT || jb == CH_DASH || jb == CH_SPACE ||
                                   jb == CH_SLASH);
                        msg_bytes.push_back(jb);
                    end
                    if (k < n - 1 || $urandom_range(0, 1)) begin
                        msg_bytes.push_back($urandom_range(0, 1) ? CH_SLASH : CH_SPACE);
                        if ($urandom_range(0, 7) == 0) begin
                            msg_bytes.push_back(CH_SPACE);   // flush with nothing pending
                        end
                    end
                end
            end
            closed = ($urandom_range(0, 9) != 0);
            for (k = 0; k < msg_bytes.size() && budget > 0; k++) begin
                queue_item(msg_bytes[k], k == 0 && $urandom_range(0, 9) != 0,
                           closed && k == msg_bytes.size() - 1);
                budget--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        int phase;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // encode at reset settings: case folding, table ends, word gap as slash
        queue_text("aZ09 ");
        // message opening on bytes outside the table: first real code has no separator
        queue_item(8'h00, 1'b1, 1'b0);
        queue_item(8'hFF, 1'b0, 1'b0);
        queue_item("e", 1'b0, 1'b1);
        settle_block();
        // no new start, so these pick up the separator; try both extremes of it
        write_reg(ADDR_SEPARATOR, 32'h0000_00FF);
        queue_item("5", 1'b0, 1'b1);
        settle_block();
        write_reg(ADDR_SEPARATOR, 32'h0000_0000);
        queue_item("M", 1'b0, 1'b1);
        settle_block();

        // decode: slash flush plus space, flush at message end
        write_reg(ADDR_DIRECTION, 32'(DIR_DECODE));
        queue_text(".-/-");
        // unknown code, empty flush, then an overlong code dropped at the end
        queue_text("..--  ......");
        // junk byte poisons the code
        queue_text("-x");
        settle_block();

        // random phases alternate direction; phase 2 carries the long hold-off,
        // phase 3 runs with no idling on either side
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            tx_idle_en = (phase != 3);
            rx_idle_en = (phase != 3);
            write_reg(ADDR_DIRECTION, 32'((phase % 2 == 0) ? DIR_ENCODE : DIR_DECODE));
            write_reg(ADDR_SEPARATOR, 32'($urandom_range(0, 255)));
            if (phase == 2) begin
                hold_req = 1'b1;
            end
            queue_random_messages(RANDOM_ITEMS / RANDOM_PHASES);
            settle_block();
        end

        if (expected_bytes.size() != 0) begin
            report_mismatch($sformatf("%0d predicted bytes never came out",
                                      expected_bytes.size()));
        end
        $display("covered %0d input bytes (%0d encoding, %0d decoding), %0d register writes",
                 items_sent, encode_items, decode_items, reg_writes);
        $display("checked %0d output bytes, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
